// File: rtl/stlb_pkg.sv
// Shared types and constants for the sorted table lower-bound search block.
`timescale 1ns / 1ps
`default_nettype none
package stlb_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 1024;
  localparam int COUNT_W             = 11;
  localparam int INDEX_W             = 10;
  localparam int VALUE_W             = 32;
  localparam int STATUS_W            = 2;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [STATUS_W-1:0] ST_FOUND       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ALL_SMALLER = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY       = 2'd2;

  typedef struct packed {
    logic                      operation;
    logic [INDEX_W-1:0]        entry_index;
    logic signed [VALUE_W-1:0] entry_value;
    logic signed [VALUE_W-1:0] target;
  } in_item_t;

  typedef struct packed {
    logic [INDEX_W-1:0]  found_index;
    logic [STATUS_W-1:0] status;
  } out_item_t;

endpackage
`default_nettype wire

// File: rtl/sorted_table_lower_bound.sv
// Sequencing: a write is taken in its accept cycle; a query with n entries in use
// runs at most ceil(log2(n+1)) probes (11 for 1024 entries), one RAM read and one
// compare each, then waits in S_OUT for a free output register, which raises
// out_valid; an empty-table query skips the probes. No new item is taken until a
// query leaves S_OUT; writes one per cycle while idle. Synchronous active-low reset
// clears the sequencer, output valid and entry_count; table contents are undefined.
`timescale 1ns / 1ps
`default_nettype none
module sorted_table_lower_bound
  import stlb_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire in_item_t           in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output out_item_t               out_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [COUNT_W-1:0] cfg_data
);

  localparam int AW   = $clog2(TABLE_DEPTH);
  localparam int CW   = $clog2(TABLE_DEPTH + 1);
  localparam int CMPW = (CW > COUNT_W) ? CW : COUNT_W;

  typedef enum logic [1:0] {S_IDLE, S_SEARCH, S_OUT} state_t;

  state_t                     state_r, state_nxt;
  logic [COUNT_W-1:0]         count_r, count_nxt;
  logic [CW-1:0]              lo_r, lo_nxt;
  logic [CW-1:0]              hi_r, hi_nxt;
  logic [CW-1:0]              n_r, n_nxt;
  logic [AW-1:0]              mid_r, mid_nxt;
  logic signed [VALUE_W-1:0]  target_r, target_nxt;
  logic [INDEX_W-1:0]         res_idx_r, res_idx_nxt;
  logic [STATUS_W-1:0]        res_status_r, res_status_nxt;
  logic                       out_valid_r, out_valid_nxt;
  out_item_t                  out_item_r, out_item_nxt;

  logic [CMPW-1:0]            cnt_ext;
  logic [CW-1:0]              n_sat;
  logic                       wr_en;
  logic [AW-1:0]              rd_addr;
  logic [VALUE_W-1:0]         rd_data;
  logic [CW-1:0]              step_lo, step_hi;
  logic [AW-1:0]              step_mid;
  logic                       step_more;

  assign cnt_ext = CMPW'(count_r);
  assign n_sat   = (cnt_ext > CMPW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(cnt_ext);

  assign wr_en = (state_r == S_IDLE) && in_valid && (in_data.operation == OP_WRITE) &&
                 (CMPW'(in_data.entry_index) < CMPW'(TABLE_DEPTH));

  assign rd_addr = (state_r == S_IDLE) ? AW'(n_sat >> 1) : step_mid;

  stlb_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(in_data.entry_index)),
    .wr_data (in_data.entry_value),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  stlb_step #(
    .CW (CW),
    .AW (AW)
  ) u_step (
    .lo      (lo_r),
    .hi      (hi_r),
    .mid     (mid_r),
    .value   ($signed(rd_data)),
    .target  (target_r),
    .lo_nxt  (step_lo),
    .hi_nxt  (step_hi),
    .mid_nxt (step_mid),
    .more    (step_more)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = cfg_valid ? cfg_data : count_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    n_nxt          = n_r;
    mid_nxt        = mid_r;
    target_nxt     = target_r;
    res_idx_nxt    = res_idx_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_item_nxt   = out_item_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_data.operation == OP_QUERY) begin
          n_nxt      = n_sat;
          lo_nxt     = '0;
          hi_nxt     = n_sat;
          mid_nxt    = rd_addr;
          target_nxt = in_data.target;
          if (n_sat == '0) begin
            res_idx_nxt    = '0;
            res_status_nxt = ST_EMPTY;
            state_nxt      = S_OUT;
          end else begin
            state_nxt = S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        lo_nxt  = step_lo;
        hi_nxt  = step_hi;
        mid_nxt = step_mid;
        if (!step_more) begin
          if (step_lo >= n_r) begin
            res_idx_nxt    = INDEX_W'(n_r - CW'(1));
            res_status_nxt = ST_ALL_SMALLER;
          end else begin
            res_idx_nxt    = INDEX_W'(step_lo);
            res_status_nxt = ST_FOUND;
          end
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        // output register frees up when empty or its transaction completes now
        if (!out_valid_r || out_ready) begin
          out_item_nxt.found_index = res_idx_r;
          out_item_nxt.status      = res_status_r;
          out_valid_nxt            = 1'b1;
          state_nxt                = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    n_r          <= n_nxt;
    mid_r        <= mid_nxt;
    target_r     <= target_nxt;
    res_idx_r    <= res_idx_nxt;
    res_status_r <= res_status_nxt;
    out_item_r   <= out_item_nxt;
  end

`ifndef ASSERT_OFF
  a_range_open: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SEARCH |-> lo_r < hi_r)
    else $error("search range empty while probing");

  a_range_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SEARCH |-> hi_r <= n_r)
    else $error("search upper bound beyond entries in use");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result shown without a finished query");

  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OUT |-> ((res_status_r == ST_EMPTY) == (n_r == '0)))
    else $error("empty status disagrees with entry count");
`endif

endmodule
`default_nettype wire

// File: rtl/stlb_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module stlb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// File: rtl/stlb_step.sv
// One bisection step: compare the probed entry with the target, narrow the range.
`timescale 1ns / 1ps
`default_nettype none
module stlb_step
  import stlb_pkg::*;
#(
  parameter int CW = 11,
  parameter int AW = 10
) (
  input  wire logic [CW-1:0]             lo,
  input  wire logic [CW-1:0]             hi,
  input  wire logic [AW-1:0]             mid,
  input  wire logic signed [VALUE_W-1:0] value,
  input  wire logic signed [VALUE_W-1:0] target,
  output logic      [CW-1:0]             lo_nxt,
  output logic      [CW-1:0]             hi_nxt,
  output logic      [AW-1:0]             mid_nxt,
  output logic                           more
);

  logic          less;
  logic [CW-1:0] mid_ext;
  logic [CW:0]   sum;

  always_comb begin
    less    = value < target;
    mid_ext = CW'(mid);
    lo_nxt  = less ? CW'(mid_ext + CW'(1)) : lo;
    hi_nxt  = less ? hi : mid_ext;
    sum     = {1'b0, lo_nxt} + {1'b0, hi_nxt};
    // only meaningful while more is set, where it stays below the table depth
    mid_nxt = AW'(sum >> 1);
    more    = lo_nxt < hi_nxt;
  end

endmodule
`default_nettype wire
